[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

[rtl/core/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// LZW byte compressor package
// Shared types and fixed constants of the compressor and its output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

	localparam int BYTE_BITS   = 8;
	localparam int OUT_BITS    = 12;
	localparam int BASE_CODES  = 256;
	localparam int QUEUE_DEPTH = 4;

	// Multiplicative hash constant (golden ratio, 32 bits).
	localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

	// One result item pushed into the output queue.
	typedef struct packed {
		logic                valid;
		logic [OUT_BITS-1:0] code;
		logic                last;
	} lbc_push_t;

endpackage

`default_nettype wire

[rtl/core/lbc_in_if.sv]
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one stream byte and its end-of-image mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       end_of_image;

	modport source (output valid, output pixel_byte, output end_of_image, input ready);
	modport sink (input valid, input pixel_byte, input end_of_image, output ready);
endinterface

`default_nettype wire

[rtl/core/lbc_out_if.sv]
// ----------------------------------------------------------------------------
// Code output channel
// Valid/ready channel carrying one emitted code and its last-code mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] code_word;
	logic        last_code;

	modport source (output valid, output code_word, output last_code, input ready);
	modport sink (input valid, input code_word, input last_code, output ready);
endinterface

`default_nettype wire

[rtl/core/lbc_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the clear_between_images register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_cfg_if;
	logic valid;
	logic ready;
	logic clear_between_images;

	modport source (output valid, output clear_between_images, input ready);
	modport sink (input valid, input clear_between_images, output ready);
endinterface

`default_nettype wire

[rtl/core/lbc_out_queue.sv]
// ----------------------------------------------------------------------------
// Output queue
// Small FIFO of result items between the compressor core and the code channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_out_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  lbc_pkg::lbc_push_t push,
	output logic              room,
	lbc_out_if.source         codes
);
	import lbc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [OUT_BITS-1:0] code_q [QUEUE_DEPTH];
	logic                last_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                pop;

	assign pop         = codes.valid && codes.ready;
	assign codes.valid = (cnt_q != '0);
	assign codes.code_word = code_q[head_q];
	assign codes.last_code = last_q[head_q];
	// room for the two results one byte can cause
	assign room = (cnt_q <= CNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push.valid) begin
				tail_q <= tail_q + PTR_W'(1);
			end
			if (pop) begin
				head_q <= head_q + PTR_W'(1);
			end
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			code_q[tail_q] <= push.code;
			last_q[tail_q] <= push.last;
		end
	end

endmodule

`default_nettype wire

[rtl/core/lzw_byte_compressor.sv]
// ----------------------------------------------------------------------------
// LZW byte compressor
// LZW encoder over a byte stream with a hashed (prefix code, byte) dictionary
// held in one synchronous memory of HASH_SLOTS entries, probed linearly.
// Codes 0 to 255 are the single bytes; new codes start at 256 and stop growing
// at 2^CODE_BITS. A byte that extends the current prefix emits nothing; a byte
// that breaks it emits the prefix code and adds the new string while a free
// slot and code space remain. The byte that carries end_of_image also
// flushes the prefix code with last_code set. The first byte of an image only
// sets the prefix in S_IDLE; any other byte passes accept and hash (S_IDLE),
// memory read (S_ADDR) and compare (S_PROBE), with one more read and compare
// for each further probed slot, and the final byte then adds a flush (S_FLUSH).
// This order is set by the single dictionary memory with its registered read
// and the serial probe chain. After reset, and after the final byte of an
// image while clear_between_images is 1, the block runs a clearing pass over
// all HASH_SLOTS slots (8192 by default), one slot a cycle, and takes no byte
// meanwhile; configuration writes are taken at any time. Up to QUEUE_DEPTH
// results queue at the output, so bytes keep flowing while codes wait to be
// taken and room for two remains. HASH_SLOTS must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_byte_compressor #(
	parameter int CODE_BITS  = 12,
	parameter int HASH_SLOTS = 8192
) (
	input  wire       clk,
	input  wire       arst_n,
	lbc_in_if.sink    pixels,
	lbc_out_if.source codes,
	lbc_cfg_if.sink   cfg
);
	import lbc_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W   = $clog2(HASH_SLOTS);
	localparam int ENTRY_W = 1 + CODE_BITS + BYTE_BITS + CODE_BITS;
	// entry layout: {valid, prefix, byte, code}
	localparam int CODE_LSB   = 0;
	localparam int BYTE_LSB   = CODE_BITS;
	localparam int PREFIX_LSB = CODE_BITS + BYTE_BITS;
	localparam int VALID_BIT  = ENTRY_W - 1;
	localparam logic [IDX_W:0] SLOT_COUNT = (IDX_W + 1)'(HASH_SLOTS);
	localparam logic [CODE_BITS:0] FIRST_FREE = (CODE_BITS + 1)'(BASE_CODES);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_ADDR  = 5'b00100,
		S_PROBE = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	// control state
	state_t               state_q;
	logic [CODE_BITS-1:0] prefix_q;
	logic                 prefix_valid_q;
	logic [CODE_BITS:0]   next_code_q;
	logic [IDX_W-1:0]     clr_addr_q;
	logic                 clear_cfg_q;

	// per-byte working registers
	logic [BYTE_BITS-1:0] byte_q;
	logic                 last_q;
	logic [31:0]          prod_s1;
	logic [IDX_W-1:0]     addr_q;
	logic [IDX_W:0]       probes_q;

	// dictionary memory
	logic [ENTRY_W-1:0]   dict_mem [HASH_SLOTS];
	logic [ENTRY_W-1:0]   rd_data_q;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENTRY_W-1:0]   wr_data;

	logic                 room;
	logic                 in_acc;
	logic [31:0]          key_ext;
	logic [IDX_W-1:0]     hash_idx;
	logic                 rd_valid;
	logic [CODE_BITS-1:0] rd_prefix;
	logic [BYTE_BITS-1:0] rd_byte;
	logic [CODE_BITS-1:0] rd_code;
	logic                 hit;
	logic                 table_full;
	logic                 resolve;
	logic                 insert;
	logic [OUT_BITS-1:0]  prefix_out;
	logic [OUT_BITS+CODE_BITS-1:0] prefix_wide;
	lbc_push_t            push;

	// The register may be written whenever the block is idle; take it always.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_cfg_q <= 1'b0;
		end else if (cfg.valid) begin
			clear_cfg_q <= cfg.clear_between_images;
		end
	end

	// Accept a byte only when idle and the queue can hold both possible results.
	assign pixels.ready = (state_q == S_IDLE) && room;
	assign in_acc       = pixels.valid && pixels.ready;

	// Hash key is (prefix, byte); the product is registered before indexing.
	assign key_ext  = 32'({16'(prefix_q), pixels.pixel_byte});
	assign hash_idx = prod_s1[7 +: IDX_W];

	// Decode the slot read in the previous cycle.
	assign rd_valid   = rd_data_q[VALID_BIT];
	assign rd_prefix  = rd_data_q[PREFIX_LSB +: CODE_BITS];
	assign rd_byte    = rd_data_q[BYTE_LSB +: BYTE_BITS];
	assign rd_code    = rd_data_q[CODE_LSB +: CODE_BITS];
	assign hit        = rd_valid && (rd_prefix == prefix_q) && (rd_byte == byte_q);
	// every slot visited with neither a match nor a free slot
	assign table_full = rd_valid && !hit && (probes_q == SLOT_COUNT);
	assign resolve    = !rd_valid || hit || table_full;
	// add the string only into a free slot and while the code space has room
	assign insert     = (state_q == S_PROBE) && !rd_valid && !next_code_q[CODE_BITS];

	// Read on the first probe and on each further probe that did not settle.
	assign rd_en   = (state_q == S_ADDR) || ((state_q == S_PROBE) && !resolve);
	assign rd_addr = (state_q == S_ADDR) ? hash_idx : addr_q + IDX_W'(1);

	// Writes happen only on a clearing pass or when a lookup settles; the next
	// read comes only in S_ADDR after S_IDLE, so no read ever meets a pending write.
	assign wr_en   = (state_q == S_CLEAR) || insert;
	assign wr_addr = (state_q == S_CLEAR) ? clr_addr_q : addr_q;
	assign wr_data = (state_q == S_CLEAR) ? '0 :
		{1'b1, prefix_q, byte_q, next_code_q[CODE_BITS-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dict_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= dict_mem[rd_addr];
		end
	end

	// Emitted codes keep the low OUT_BITS bits of the prefix, zero-padded.
	assign prefix_wide = {OUT_BITS'(0), prefix_q};
	assign prefix_out  = prefix_wide[OUT_BITS-1:0];

	always_comb begin
		push       = '0;
		push.code  = prefix_out;
		case (state_q)
			S_PROBE: begin
				push.valid = resolve && !hit;
				push.last  = 1'b0;
			end
			S_FLUSH: begin
				push.valid = 1'b1;
				push.last  = 1'b1;
			end
			default: begin
				push.valid = 1'b0;
				push.last  = 1'b0;
			end
		endcase
	end

	lbc_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.codes  (codes)
	);

	// Sequencer: hash, read, compare and probe, then flush or clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			prefix_q       <= '0;
			prefix_valid_q <= 1'b0;
			next_code_q    <= FIRST_FREE;
			clr_addr_q     <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + IDX_W'(1);
					if (clr_addr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (prefix_valid_q) begin
							state_q <= S_ADDR;
						end else begin
							// first byte of an image: it becomes the prefix
							prefix_q       <= CODE_BITS'(pixels.pixel_byte);
							prefix_valid_q <= 1'b1;
							if (pixels.end_of_image) begin
								state_q <= S_FLUSH;
							end
						end
					end
				end
				S_ADDR: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (resolve) begin
						if (hit) begin
							prefix_q <= rd_code;
						end else begin
							prefix_q <= CODE_BITS'(byte_q);
						end
						if (insert) begin
							next_code_q <= next_code_q + (CODE_BITS + 1)'(1);
						end
						state_q <= last_q ? S_FLUSH : S_IDLE;
					end
				end
				S_FLUSH: begin
					prefix_q       <= '0;
					prefix_valid_q <= 1'b0;
					if (clear_cfg_q) begin
						clr_addr_q  <= '0;
						next_code_q <= FIRST_FREE;
						state_q     <= S_CLEAR;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers: hold the byte and hash product, advance the probe address and count.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_q  <= pixels.pixel_byte;
			last_q  <= pixels.end_of_image;
			prod_s1 <= key_ext * HASH_MULT;
		end
		if (state_q == S_ADDR) begin
			addr_q   <= hash_idx;
			probes_q <= (IDX_W + 1)'(1);
		end else if ((state_q == S_PROBE) && !resolve) begin
			addr_q   <= addr_q + IDX_W'(1);
			probes_q <= probes_q + (IDX_W + 1)'(1);
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`ASSERT_CLK(a_code_space, next_code_q <= {1'b1, {CODE_BITS{1'b0}}}, "next free code beyond code space")
	`ASSERT_IMPL(a_clear_base, state_q == S_CLEAR, next_code_q == FIRST_FREE, "clearing pass without code reset")
	`ASSERT_IMPL(a_probe_bound, state_q == S_PROBE, (probes_q != '0) && (probes_q <= SLOT_COUNT), "probe count out of range")
	`ASSERT_NEXT(a_lookup_start, in_acc && prefix_valid_q, state_q == S_ADDR, "lookup did not start after accepted byte")

endmodule

`default_nettype wire
